### rtl/assert_macros.svh
// Assertion macros shared by the hasher RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define SHS_ASSERT_HOLD(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define SHS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the antecedent
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sha256sh_pkg.sv
// Types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; used by sha256sh_core and sha256_stream_hasher.
package sha256sh_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       shift_en;
		logic [7:0] shift_byte;
		logic       start;
		logic       reinit;
	} core_ctrl_t;

	localparam logic       REQ_APPEND = 1'b0;
	localparam logic       REQ_FINISH = 1'b1;
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [2:0] LEN_ZONE   = 3'b111;  // byte slots 56..63 hold the bit length
	localparam logic [5:0] LAST_SLOT  = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [1:0] LAST_PART  = 2'd3;

	localparam logic [7:0][31:0] HASH_IV = {
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
		32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
		32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
		32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
		32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
		32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

### rtl/sha256sh_core.sv
// Block buffer, message schedule window and shared round unit of the hasher.
// Depends on sha256sh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sha256sh_core
	import sha256sh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  core_ctrl_t       ctrl,
	output logic             done,
	output logic [7:0][31:0] digest
);

	// 512-bit byte shift line; doubles as the 16-word schedule window, word 0 on top
	logic [511:0]     win_q;
	logic [7:0][31:0] vars_q;
	logic [7:0][31:0] hash_q;
	logic [5:0]       round_q;
	logic             run_q;
	logic             fin_q;

	logic [31:0] w0, w1, w9, w14, w_next;
	logic [31:0] t1, t2, va, ve;

	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];

	// schedule word sixteen positions ahead of word 0
	assign w_next = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

	assign va = vars_q[0];
	assign ve = vars_q[4];
	assign t1 = vars_q[7] + big_sigma1(ve) + ((ve & vars_q[5]) ^ (~ve & vars_q[6]))
		+ ROUND_K[round_q] + w0;
	assign t2 = big_sigma0(va)
		+ ((va & vars_q[1]) ^ (va & vars_q[2]) ^ (vars_q[1] & vars_q[2]));

	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			win_q <= {win_q[503:0], ctrl.shift_byte};
		end else if (run_q) begin
			win_q <= {win_q[479:0], w_next};
		end
		if (ctrl.start) begin
			vars_q <= hash_q;
		end else if (run_q) begin
			vars_q <= {vars_q[6:4], vars_q[3] + t1, vars_q[2:0], t1 + t2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
			hash_q  <= HASH_IV;
		end else begin
			fin_q <= 1'b0;
			if (ctrl.start) begin
				round_q <= '0;
				run_q   <= 1'b1;
			end else if (run_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == LAST_ROUND) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (ctrl.reinit) begin
				hash_q <= HASH_IV;
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + vars_q[i];
				end
			end
		end
	end

	assign done   = fin_q;
	assign digest = hash_q;

	`SHS_ASSERT_IMPL(a_start_when_free, ctrl.start, !run_q && !fin_q, "start while compressing")
	`SHS_ASSERT_NEXT(a_round_end, run_q && (round_q == LAST_ROUND), fin_q && !run_q, "no final add")
	`SHS_ASSERT_HOLD(a_no_shift_in_run, !(ctrl.shift_en && run_q), "byte shifted during rounds")

endmodule

### rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: request sequencer, padding and digest output.
// Depends on sha256sh_pkg, sha256sh_core and assert_macros.svh.
//
//  channel | signals                          | carries
//  --------+----------------------------------+-------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser| one request: append byte or finish
//  output  | m_tvalid m_tready m_tdata m_tuser| digest quarters, m_tlast on the fourth
//          | m_tlast                          |
//
// Append: the byte enters the block; the 64th byte of a block starts its compression
// (64 rounds in one shared round unit, then the hash word add).
// Finish: pad bytes go in one per cycle up to the block end, then one or two
// compressions run, then four digest parts go out, each held while the sink stalls.
// s_tready is low from a finish until the last digest part is taken, and during rounds.
// Reset loads the initial hash values and clears byte count and fill position.
`include "assert_macros.svh"

module sha256_stream_hasher
	import sha256sh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] digest_part
	output logic [1:0]  m_tuser,   // [1:0] part_index
	output logic        m_tlast
);

	state_t           state_q, state_d;
	core_ctrl_t       ctrl;
	logic             core_done;
	logic [7:0][31:0] digest;

	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic        pad_q;
	logic        first_q;
	logic        extra_q;
	logic        final_q;
	logic [1:0]  part_q;

	logic        in_req, out_req, append_req, finish_req;
	logic        len_slot;
	logic [63:0] len_bits;
	logic [2:0]  len_sel;
	logic [7:0]  len_byte, pad_byte;

	assign in_req     = s_tvalid && s_tready;
	assign out_req    = m_tvalid && m_tready;
	assign append_req = in_req && (s_tuser == REQ_APPEND);
	assign finish_req = in_req && (s_tuser == REQ_FINISH);

	// length bytes go in the last eight slots of the final block, most significant first
	assign len_slot = (fill_q[5:3] == LEN_ZONE) && !extra_q && !first_q;
	assign len_bits = {len_q, 3'b000};
	assign len_sel  = 3'd7 - fill_q[2:0];
	assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

	always_comb begin
		if (first_q) begin
			pad_byte = PAD_MARK;
		end else if (len_slot) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (finish_req) begin
					state_d = ST_PAD;
				end else if (append_req) begin
					ctrl.shift_en   = 1'b1;
					ctrl.shift_byte = s_tdata;
					if (fill_q == LAST_SLOT) begin
						ctrl.start = 1'b1;
						state_d    = ST_COMP;
					end
				end
			end
			ST_PAD: begin
				ctrl.shift_en   = 1'b1;
				ctrl.shift_byte = pad_byte;
				if (fill_q == LAST_SLOT) begin
					ctrl.start = 1'b1;
					state_d    = ST_COMP;
				end
			end
			ST_COMP: begin
				if (core_done) begin
					if (final_q) begin
						state_d = ST_OUT;
					end else if (pad_q) begin
						state_d = ST_PAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready && (part_q == LAST_PART)) begin
					ctrl.reinit = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			len_q   <= '0;
			pad_q   <= 1'b0;
			first_q <= 1'b0;
			extra_q <= 1'b0;
			final_q <= 1'b0;
			part_q  <= '0;
		end else begin
			if (ctrl.shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (ctrl.reinit) begin
				len_q <= '0;
			end else if (append_req) begin
				len_q <= len_q + 61'd1;
			end
			if (finish_req) begin
				pad_q   <= 1'b1;
				first_q <= 1'b1;
			end else if (state_q == ST_PAD) begin
				first_q <= 1'b0;
			end
			if (ctrl.reinit) begin
				pad_q <= 1'b0;
			end
			// marker landing past slot 55 leaves no room for the length in this block
			if (ctrl.start) begin
				extra_q <= 1'b0;
			end else if ((state_q == ST_PAD) && first_q && (fill_q[5:3] == LEN_ZONE)) begin
				extra_q <= 1'b1;
			end
			if (ctrl.reinit) begin
				final_q <= 1'b0;
			end else if (ctrl.start && (state_q == ST_PAD)) begin
				final_q <= len_slot;
			end
			if (out_req) begin
				part_q <= part_q + 2'd1;
			end
		end
	end

	sha256sh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.done   (core_done),
		.digest (digest)
	);

	assign m_tdata = {digest[{part_q, 1'b0}], digest[{part_q, 1'b1}]};
	assign m_tuser = part_q;
	assign m_tlast = (part_q == LAST_PART);

	`SHS_ASSERT_HOLD(a_one_side, !(s_tready && m_tvalid), "input open while digest pending")
	`SHS_ASSERT_NEXT(a_back_idle, out_req && m_tlast, s_tready && (part_q == 2'd0), "no return")
	`SHS_ASSERT_NEXT(a_pad_wrap, (state_q == ST_PAD) && (fill_q == LAST_SLOT),
		(state_q == ST_COMP) && (fill_q == 6'd0), "padding block not compressed")
	`SHS_ASSERT_IMPL(a_out_final, state_q == ST_OUT, final_q && pad_q, "digest before last block")

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for sha256_stream_hasher: byte requests in, digest quarters out.
// Depends on sha256sh_pkg and the hasher RTL; an in-bench SHA-256 model predicts each digest.
module tb_top
	import sha256sh_pkg::*;
();

	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 400;
	localparam int TAIL_WAIT  = 300;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_b;
	} hash_req_t;

	typedef struct packed {
		logic [63:0] part;
		logic [1:0]  idx;
		logic        last;
	} digest_part_t;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
	logic        s_tuser  = 1'b0;    // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;            // [63:0] digest_part
	logic [1:0]  m_tuser;            // [1:0] part_index
	logic        m_tlast;

	hash_req_t    pending [$];
	digest_part_t digest_due [$];

	int send_idle_pct = 9;
	int recv_idle_pct = 46;
	int fails         = 0;
	int idle_cycles   = 0;
	int hold_left     = 0;
	bit req_taken     = 1'b0;
	bit hold_armed    = 1'b0;

	// model state
	logic [31:0] hv [8];
	logic [7:0]  blk [64];
	int          fill_pos;
	logic [60:0] msg_len;

	sha256_stream_hasher uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void sha_reset_state();
		for (int j = 0; j < 8; j++) hv[j] = SHA_IV[j];
		fill_pos = 0;
		msg_len  = '0;
	endfunction

	function automatic void sha_compress();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wt, t1, t2, x15, x2;
		for (int j = 0; j < 8; j++) v[j] = hv[j];
		for (int t = 0; t < 64; t++) begin
			if (t < 16) begin
				wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			end else begin
				x15 = w[(t - 15) % 16];
				x2  = w[(t - 2) % 16];
				wt  = w[t % 16] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
				    + w[(t - 7) % 16] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
			end
			w[t % 16] = wt;
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
			   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + wt;
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
			   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++) hv[j] = hv[j] + v[j];
	endfunction

	// Absorb one accepted request; a finish pads, compresses and queues the digest.
	function automatic void sha_absorb(input hash_req_t r);
		logic [63:0]  bitlen;
		digest_part_t dp;
		if (r.kind == REQ_APPEND) begin
			blk[fill_pos] = r.data_b;
			fill_pos++;
			msg_len++;
			if (fill_pos == 64) begin
				sha_compress();
				fill_pos = 0;
			end
		end else begin
			bitlen = {msg_len, 3'b000};
			blk[fill_pos] = PAD_BYTE;
			fill_pos++;
			// no room left for the length: spill into a second block
			if (fill_pos > 56) begin
				for (int k = fill_pos; k < 64; k++) blk[k] = 8'h00;
				sha_compress();
				fill_pos = 0;
			end
			for (int k = fill_pos; k < 56; k++) blk[k] = 8'h00;
			for (int k = 0; k < 8; k++) blk[63 - k] = bitlen[8*k +: 8];
			sha_compress();
			for (int k = 0; k < 4; k++) begin
				dp.part = {hv[2*k], hv[2*k+1]};
				dp.idx  = 2'(k);
				dp.last = (k == 3);
				digest_due.push_back(dp);
			end
			sha_reset_state();
		end
	endfunction

	function automatic void push_req(input logic kind, input logic [7:0] data_b);
		hash_req_t r;
		r.kind   = kind;
		r.data_b = data_b;
		pending.push_back(r);
	endfunction

	task automatic drain_all();
		while (pending.size() != 0 || s_tvalid || digest_due.size() != 0) @(posedge clk);
	endtask

	// Output check first, then prediction of the accepted request, then the watchdog.
	always @(posedge clk) begin : sample
		digest_part_t want;
		hash_req_t    got_req;
		bit           moved;
		moved = 1'b0;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				if (digest_due.size() == 0) begin
					$error("digest part with none expected: %h", m_tdata);
					fails++;
				end else begin
					want = digest_due.pop_front();
					if (m_tdata !== want.part) begin
						$error("digest_part: expected %h, actual %h", want.part, m_tdata);
						fails++;
					end
					if (m_tuser !== want.idx) begin
						$error("part_index: expected %0d, actual %0d", want.idx, m_tuser);
						fails++;
					end
					if (m_tlast !== want.last) begin
						$error("is_last: expected %0b, actual %0b", want.last, m_tlast);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				moved          = 1'b1;
				got_req.kind   = s_tuser;
				got_req.data_b = s_tdata;
				sha_absorb(got_req);
				req_taken = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Request driver: holds a request until taken, then maybe idles.
	always @(negedge clk) begin : drive
		hash_req_t nxt;
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= nxt.kind;
				s_tdata  <= nxt.data_b;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		req_taken = 1'b0;
	end

	// Digest sink: random stalls plus one long hold once armed.
	always @(negedge clk) begin : sink
		if (hold_armed && m_tvalid) begin
			hold_armed = 1'b0;
			hold_left  = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : stimulus
		int n, msgs, len;
		sha_reset_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty message
		push_req(REQ_FINISH, 8'h00);
		// "abc", finish carries a junk byte
		push_req(REQ_APPEND, 8'h61);
		push_req(REQ_APPEND, 8'h62);
		push_req(REQ_APPEND, 8'h63);
		push_req(REQ_FINISH, 8'hFF);
		// byte extremes
		push_req(REQ_APPEND, 8'h00);
		push_req(REQ_APPEND, 8'hFF);
		push_req(REQ_FINISH, 8'h5A);
		// empty again, right after a digest
		push_req(REQ_FINISH, 8'hA5);
		push_req(REQ_APPEND, PAD_BYTE);
		push_req(REQ_APPEND, 8'h55);
		push_req(REQ_APPEND, 8'hAA);
		push_req(REQ_FINISH, 8'h00);

		for (int ph = 0; ph < 3; ph++) begin
			// sender pauses until every digest is back
			drain_all();
			case (ph)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_armed    = 1'b1;
				end
			endcase
			n    = 0;
			msgs = 0;
			while (n < 36 || msgs < 2) begin
				// lengths cluster around the one/two block padding boundary
				case ($urandom_range(9))
					0, 1, 2: len = $urandom_range(8);
					3, 4, 5: len = $urandom_range(66, 52);
					6:       len = $urandom_range(130, 110);
					default: len = $urandom_range(70);
				endcase
				for (int i = 0; i < len; i++) push_req(REQ_APPEND, 8'($urandom_range(255)));
				push_req(REQ_FINISH, 8'($urandom_range(255)));
				n += len + 1;
				msgs++;
			end
		end

		drain_all();
		repeat (TAIL_WAIT) @(posedge clk);
		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
